### hw/rtl/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg: shared definitions for the anisotropic Morton codec
// Field widths, lane counts, action codes and the bit placement function
// that maps (dimension, coordinate bit) to a position in the Morton index.
// ----------------------------------------------------------------------------
package amc_pkg;

    // Hardware lanes, active dimensions and level saturation
    localparam int NDIM      = 3;
    localparam int DIMS      = 3;
    localparam int MAX_LEVEL = 16;

    // Field widths
    localparam int IDX_W = 48;
    localparam int CRD_W = 16;
    localparam int LVL_W = 5;
    localparam int POS_W = $clog2(IDX_W);
    localparam int SUM_W = POS_W + 1;

    // Action codes
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef logic [LVL_W-1:0]       level_t;
    typedef level_t [NDIM-1:0]      level_vec_t;
    typedef logic [CRD_W-1:0]       coord_t;
    typedef coord_t [NDIM-1:0]      coord_vec_t;
    typedef logic [IDX_W-1:0]       index_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef pos_t [CRD_W-1:0]       pos_row_t;
    typedef pos_row_t [NDIM-1:0]    pos_tab_t;
    typedef logic [CRD_W-1:0]       en_row_t;
    typedef en_row_t [NDIM-1:0]     en_tab_t;

    // Saturate a raw level and zero lanes beyond the active dimension count
    function automatic level_t sat_level(input level_t raw, input int d);
        level_t l;
        l = raw;
        if (l > level_t'(MAX_LEVEL)) begin
            l = level_t'(MAX_LEVEL);
        end
        if (d >= DIMS) begin
            l = '0;
        end
        return l;
    endfunction

    // Index position of bit k of dimension d. All bits of lower rounds come
    // first (sum of min(level, k)), then the dimensions ahead of d in
    // this round: lower level, or equal level and lower dimension number.
    function automatic pos_t bit_pos(input level_vec_t lv, input int d, input int k);
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int e = 0; e < NDIM; e++) begin
            if (lv[e] < level_t'(k)) begin
                acc = acc + SUM_W'(lv[e]);
            end else begin
                acc = acc + SUM_W'(k);
            end
            if (lv[e] > level_t'(k) &&
                (lv[e] < lv[d] || (lv[e] == lv[d] && e < d))) begin
                acc = acc + SUM_W'(1);
            end
        end
        return acc[POS_W-1:0];
    endfunction

endpackage

### hw/rtl/anisotropic_morton_codec.sv
// ----------------------------------------------------------------------------
// anisotropic_morton_codec: Z-order encode/decode with per-dimension levels
// Packs three coordinates into one Morton index, or splits an index back
// into coordinates, with each dimension refined to its own level.
// ----------------------------------------------------------------------------
// Two-stage pipeline, one beat per cycle sustained while m_ready is high; an
// accepted beat passes the stage 1 registers, then the result register. The
// first stage saturates the levels and works out the index position of every
// coordinate bit; the second routes the bits through a 48-way crossbar into
// the result register. Both stages move together on one enable, so a stalled
// result holds the pipeline and s_ready follows m_ready while the result
// register is full. s_ready is held low during reset.
module anisotropic_morton_codec (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  amc_pkg::coord_t       s_coord_0,
    input  amc_pkg::coord_t       s_coord_1,
    input  amc_pkg::coord_t       s_coord_2,
    input  amc_pkg::level_t       s_level_0,
    input  amc_pkg::level_t       s_level_1,
    input  amc_pkg::level_t       s_level_2,
    input  amc_pkg::index_t       s_z_index,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output amc_pkg::index_t       m_z_result,
    output amc_pkg::coord_t       m_coord_out_0,
    output amc_pkg::coord_t       m_coord_out_1,
    output amc_pkg::coord_t       m_coord_out_2
);
    import amc_pkg::*;

    logic       advance;
    level_vec_t lvl_sat;
    pos_tab_t   pos_next;
    en_tab_t    en_next;

    logic       s1_valid_reg;
    logic       s1_action_reg;
    coord_vec_t s1_coord_reg;
    index_t     s1_z_reg;
    pos_tab_t   s1_pos_reg;
    en_tab_t    s1_en_reg;

    logic       m_valid_reg;
    logic       m_action_reg;
    index_t     z_result_reg;
    index_t     z_result_next;
    coord_vec_t coord_out_reg;
    coord_vec_t coord_out_next;

    // Pipeline moves whenever the result slot is free or being emptied
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = aresetn && advance;

    // Stage 1 logic: saturated levels and bit placement table
    always_comb begin
        lvl_sat[0] = sat_level(s_level_0, 0);
        lvl_sat[1] = sat_level(s_level_1, 1);
        lvl_sat[2] = sat_level(s_level_2, 2);
        for (int d = 0; d < NDIM; d++) begin
            for (int k = 0; k < CRD_W; k++) begin
                pos_next[d][k] = bit_pos(lvl_sat, d, k);
                en_next[d][k]  = (lvl_sat[d] > level_t'(k));
            end
        end
    end

    // Stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_action_reg   <= s_action;
            s1_coord_reg[0] <= s_coord_0;
            s1_coord_reg[1] <= s_coord_1;
            s1_coord_reg[2] <= s_coord_2;
            s1_z_reg        <= s_z_index;
            s1_pos_reg      <= pos_next;
            s1_en_reg       <= en_next;
        end
    end

    // Stage 2 logic: crossbar between coordinate bits and index bits
    always_comb begin
        z_result_next  = '0;
        coord_out_next = '0;
        for (int d = 0; d < NDIM; d++) begin
            for (int k = 0; k < CRD_W; k++) begin
                if (s1_en_reg[d][k]) begin
                    if (s1_action_reg == ACT_DECODE) begin
                        coord_out_next[d][k] = s1_z_reg[s1_pos_reg[d][k]];
                    end else begin
                        z_result_next[s1_pos_reg[d][k]] = s1_coord_reg[d][k];
                    end
                end
            end
        end
    end

    // Result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_action_reg  <= s1_action_reg;
            z_result_reg  <= z_result_next;
            coord_out_reg <= coord_out_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_z_result    = z_result_reg;
    assign m_coord_out_0 = coord_out_reg[0];
    assign m_coord_out_1 = coord_out_reg[1];
    assign m_coord_out_2 = coord_out_reg[2];

    // Checks
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !s1_valid_reg)
        else $error("pipeline not empty after reset");

    a_stage_move: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && advance |=> m_valid_reg)
        else $error("stage 1 beat lost on advance");

    a_decode_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_action_reg == ACT_DECODE |-> z_result_reg == '0)
        else $error("decode beat carries an index");

    a_encode_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_action_reg == ACT_ENCODE |-> coord_out_reg == '0)
        else $error("encode beat carries coordinates");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(z_result_reg)
            && $stable(coord_out_reg))
        else $error("stalled result changed");

endmodule
